@@ src/fan_mode_speed_controller_macros.svh @@
// assertion macros shared by the fan mode and speed controller
`ifndef FAN_MODE_SPEED_CONTROLLER_MACROS_SVH
`define FAN_MODE_SPEED_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define FMSC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FMSC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define FMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/fmsc_pkg.sv @@
// types, constants and helpers of the fan mode and speed controller
`timescale 1ns / 1ps

package fmsc_pkg;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned TEMP_W  = 8;
    localparam int unsigned KEY_W   = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DUTY_W-1:0] SPEED_STEP = 7'd10;
    localparam logic [DUTY_W-1:0] SPEED_MAX  = 7'd100;
    localparam logic [DUTY_W-1:0] SLOW_LIMIT = 7'd30;

    // temperature band edges, the gap values hold the previous speed
    localparam logic [TEMP_W-1:0] TEMP_STOP_BELOW = 8'd20;
    localparam logic [TEMP_W-1:0] TEMP_SLOW_LO    = 8'd21;
    localparam logic [TEMP_W-1:0] TEMP_SLOW_HI    = 8'd25;
    localparam logic [TEMP_W-1:0] TEMP_MED_LO     = 8'd26;
    localparam logic [TEMP_W-1:0] TEMP_MED_HI     = 8'd30;
    localparam logic [TEMP_W-1:0] TEMP_FAST_LO    = 8'd31;

    localparam logic [DUTY_W-1:0] SLOW_DUTY_RST   = 7'd30;
    localparam logic [DUTY_W-1:0] MEDIUM_DUTY_RST = 7'd60;
    localparam logic [DUTY_W-1:0] FAST_DUTY_RST   = 7'd90;

    typedef enum logic [MODE_W-1:0] {
        MODE_SETTINGS = 2'd0,
        MODE_MANUAL   = 2'd1,
        MODE_AUTO     = 2'd2
    } mode_t;

    typedef enum logic [KEY_W-1:0] {
        KEY_NONE     = 3'd0,
        KEY_MANUAL   = 3'd1,
        KEY_AUTO     = 3'd2,
        KEY_UP       = 3'd3,
        KEY_DOWN     = 3'd4,
        KEY_SETTINGS = 3'd5
    } key_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_DUTY   = 2'd0,
        REG_MEDIUM_DUTY = 2'd1,
        REG_FAST_DUTY   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] slow_duty;
        logic [DUTY_W-1:0] medium_duty;
        logic [DUTY_W-1:0] fast_duty;
    } duty_cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [DUTY_W-1:0] speed;
        logic              drive_on;
        logic [DUTY_W-1:0] drive_duty;
        logic [TEMP_W-1:0] prev_temp;
        logic [DUTY_W-1:0] prev_speed;
    } ctrl_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode_now;
        logic              motor_on;
        logic [DUTY_W-1:0] motor_duty;
        logic [DUTY_W-1:0] speed_value;
        logic [TEMP_W-1:0] shown_temperature;
        logic              refresh_display;
    } result_t;

    function automatic logic [DUTY_W-1:0] cap100(input logic [DUTY_W-1:0] v);
        return (v > SPEED_MAX) ? SPEED_MAX : v;
    endfunction

endpackage

@@ src/fmsc_in_if.sv @@
// input channel: one control tick with key and temperature
`timescale 1ns / 1ps

interface fmsc_in_if;
    import fmsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_code;
    logic [TEMP_W-1:0] temperature;

    modport source (output valid, output key_code, output temperature, input ready);
    modport sink   (input valid, input key_code, input temperature, output ready);
endinterface

@@ src/fmsc_out_if.sv @@
// result channel: mode, motor drive, speed and display refresh
`timescale 1ns / 1ps

interface fmsc_out_if;
    import fmsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode_now;
    logic              motor_on;
    logic [DUTY_W-1:0] motor_duty;
    logic [DUTY_W-1:0] speed_value;
    logic [TEMP_W-1:0] shown_temperature;
    logic              refresh_display;

    modport source (output valid, output mode_now, output motor_on, output motor_duty,
                    output speed_value, output shown_temperature, output refresh_display,
                    input ready);
    modport sink   (input valid, input mode_now, input motor_on, input motor_duty,
                    input speed_value, input shown_temperature, input refresh_display,
                    output ready);
endinterface

@@ src/fmsc_cfg_if.sv @@
// configuration write channel: register index and write data
`timescale 1ns / 1ps

interface fmsc_cfg_if;
    import fmsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DUTY_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ src/fmsc_cfg.sv @@
// duty configuration registers
`timescale 1ns / 1ps

module fmsc_cfg
    import fmsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fmsc_cfg_if.sink   cfg,
    output duty_cfg_t  duty
);

    duty_cfg_t duty_reg;
    duty_cfg_t duty_next;
    logic      wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_comb
    begin
        duty_next = duty_reg;
        if (wr_en)
        begin
            unique case (cfg.reg_index)
                REG_SLOW_DUTY:   duty_next.slow_duty   = cfg.wr_data;
                REG_MEDIUM_DUTY: duty_next.medium_duty = cfg.wr_data;
                REG_FAST_DUTY:   duty_next.fast_duty   = cfg.wr_data;
                default:         duty_next = duty_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg.slow_duty   <= SLOW_DUTY_RST;
            duty_reg.medium_duty <= MEDIUM_DUTY_RST;
            duty_reg.fast_duty   <= FAST_DUTY_RST;
        end
        else
        begin
            duty_reg <= duty_next;
        end
    end

    assign duty = duty_reg;

endmodule

@@ src/fmsc_step.sv @@
// per-tick mode, speed, motor and refresh logic
`timescale 1ns / 1ps

module fmsc_step
    import fmsc_pkg::*;
(
    input  ctrl_state_t        state_cur,
    input  duty_cfg_t          duty,
    input  logic [KEY_W-1:0]   key_code,
    input  logic [TEMP_W-1:0]  temperature,
    output ctrl_state_t        state_next,
    output result_t            result
);

    key_t              key;
    ctrl_state_t       nxt;
    logic              refresh;
    logic [DUTY_W:0]   speed_up;
    logic [TEMP_W-1:0] temp_diff;

    assign key = key_t'(key_code);

    always_comb
    begin
        nxt       = state_cur;
        refresh   = 1'b0;
        speed_up  = {1'b0, state_cur.speed} + {1'b0, SPEED_STEP};
        temp_diff = (temperature > state_cur.prev_temp) ? (temperature - state_cur.prev_temp)
                                                        : (state_cur.prev_temp - temperature);

        unique case (state_cur.mode)
            MODE_MANUAL:
            begin
                if (key == KEY_UP)
                begin
                    if (state_cur.speed < SPEED_MAX)
                    begin
                        nxt.speed = (speed_up > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                                   : speed_up[DUTY_W-1:0];
                        refresh   = 1'b1;
                    end
                end
                else if (key == KEY_DOWN)
                begin
                    if (state_cur.speed != '0)
                    begin
                        nxt.speed = (state_cur.speed > SPEED_STEP) ? state_cur.speed - SPEED_STEP
                                                                   : '0;
                        refresh   = 1'b1;
                    end
                end
                else if (key == KEY_SETTINGS)
                begin
                    nxt.mode = MODE_SETTINGS;
                    refresh  = 1'b1;
                end

                // motor follows the new speed on the same tick
                priority if (nxt.speed == '0)
                begin
                    nxt.drive_on   = 1'b0;
                    nxt.drive_duty = '0;
                end
                else if (nxt.speed <= SLOW_LIMIT)
                begin
                    nxt.drive_on   = 1'b1;
                    nxt.drive_duty = cap100(duty.slow_duty);
                end
                else
                begin
                    nxt.drive_on   = 1'b1;
                    nxt.drive_duty = cap100(nxt.speed);
                end
            end

            MODE_AUTO:
            begin
                // gap temperatures fall through and hold speed and motor
                if (temperature < TEMP_STOP_BELOW)
                begin
                    nxt.speed      = '0;
                    nxt.drive_on   = 1'b0;
                    nxt.drive_duty = '0;
                end
                else if (temperature > TEMP_SLOW_LO && temperature < TEMP_SLOW_HI)
                begin
                    nxt.speed      = cap100(duty.slow_duty);
                    nxt.drive_on   = 1'b1;
                    nxt.drive_duty = cap100(duty.slow_duty);
                end
                else if (temperature > TEMP_MED_LO && temperature < TEMP_MED_HI)
                begin
                    nxt.speed      = cap100(duty.medium_duty);
                    nxt.drive_on   = 1'b1;
                    nxt.drive_duty = cap100(duty.medium_duty);
                end
                else if (temperature > TEMP_FAST_LO)
                begin
                    nxt.speed      = cap100(duty.fast_duty);
                    nxt.drive_on   = 1'b1;
                    nxt.drive_duty = cap100(duty.fast_duty);
                end

                if (temp_diff > 8'd1 || nxt.speed != state_cur.prev_speed)
                begin
                    refresh = 1'b1;
                end
                nxt.prev_temp  = temperature;
                nxt.prev_speed = nxt.speed;

                if (key == KEY_SETTINGS)
                begin
                    nxt.mode = MODE_SETTINGS;
                    refresh  = 1'b1;
                end
            end

            default:
            begin
                // settings, and the unreachable fourth code behaves the same
                if (key == KEY_MANUAL)
                begin
                    nxt.mode = MODE_MANUAL;
                    refresh  = 1'b1;
                end
                else if (key == KEY_AUTO)
                begin
                    nxt.mode = MODE_AUTO;
                    refresh  = 1'b1;
                end
            end
        endcase
    end

    assign state_next = nxt;

    always_comb
    begin
        result.mode_now          = nxt.mode;
        result.motor_on          = nxt.drive_on;
        result.motor_duty        = nxt.drive_duty;
        result.speed_value       = nxt.speed;
        result.shown_temperature = nxt.prev_temp;
        result.refresh_display   = refresh;
    end

endmodule

@@ src/fan_mode_speed_controller.sv @@
// fan mode and speed controller top level
//
// in_ch carries one control tick per request: a decoded key and a temperature
// sample. out_ch returns exactly one result per tick, in order: the mode after
// the tick, the motor drive (on and duty percent), the speed setting, the last
// temperature taken in auto mode and a flag that the display must be redrawn.
// cfg writes the slow, medium and fast duty registers (index 0, 1, 2); it is
// always ready and writes to other indexes are dropped. Write it while idle.
// The tick is captured in an input register at the accepting edge, the control
// logic runs on the held tick and the result lands in the output register at
// the edge where the held tick moves on, which waits while the output register
// is full and not being drained.
// Throughput is one tick per cycle while out_ch stays ready; the control logic
// also updates the state when the tick moves on.
// When out_ch stalls, the result holds, the input register still takes one
// more tick, and in_ch.ready drops only once both registers are full.
// Reset puts the block in settings mode with speed zero, the motor stopped,
// the stored temperature zero and the duty registers at 30, 60 and 90.
`timescale 1ns / 1ps
`include "fan_mode_speed_controller_macros.svh"

module fan_mode_speed_controller
    import fmsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fmsc_in_if.sink    in_ch,
    fmsc_out_if.source out_ch,
    fmsc_cfg_if.sink   cfg
);

    duty_cfg_t         duty;
    logic              in_valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic              advance;
    logic              in_take;

    fmsc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .duty  (duty)
    );

    fmsc_step u_step (
        .state_cur   (state_reg),
        .duty        (duty),
        .key_code    (key_reg),
        .temperature (temp_reg),
        .state_next  (state_next),
        .result      (res_next)
    );

    // the held tick moves on when the result register is free or being drained
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            key_reg  <= in_ch.key_code;
            temp_reg <= in_ch.temperature;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_SETTINGS;
            state_reg.speed      <= '0;
            state_reg.drive_on   <= 1'b0;
            state_reg.drive_duty <= '0;
            state_reg.prev_temp  <= '0;
            state_reg.prev_speed <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.mode_now          = res_reg.mode_now;
    assign out_ch.motor_on          = res_reg.motor_on;
    assign out_ch.motor_duty        = res_reg.motor_duty;
    assign out_ch.speed_value       = res_reg.speed_value;
    assign out_ch.shown_temperature = res_reg.shown_temperature;
    assign out_ch.refresh_display   = res_reg.refresh_display;

    `FMSC_ASSERT_ALWAYS(a_speed_range, clk, rst_n, state_reg.speed <= SPEED_MAX,
        "stored speed above 100")
    `FMSC_ASSERT_ALWAYS(a_stopped_no_duty, clk, rst_n,
        state_reg.drive_on || state_reg.drive_duty == '0, "stopped motor with nonzero duty")
    `FMSC_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(state_reg),
        "state changed without a tick moving on")
    `FMSC_ASSERT_NEXT(a_tick_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg,
        "held tick dropped while the result register was full")
    `FMSC_ASSERT_NEXT(a_result_shown, clk, rst_n, advance, out_valid_reg,
        "tick moved on without a result")

endmodule
